// ----- hdl/acfd_pkg.sv -----
// ----------------------------------------------------------------------------
// acfd_pkg
// Shared types, constants and the byte-wide CRC-16 function of the
// ACARS frame deframer.
// ----------------------------------------------------------------------------
package acfd_pkg;

  localparam int unsigned CHANNELS = 2;

  localparam logic [7:0]  PreambleByte = 8'hFF;
  localparam logic [7:0]  BitSync1     = 8'hAB;
  localparam logic [7:0]  BitSync2     = 8'h2A;
  localparam logic [6:0]  CharEtx      = 7'h03;
  localparam logic [6:0]  CharEtb      = 7'h17;
  localparam logic [3:0]  BitsByte     = 4'd8;
  localparam logic [3:0]  BitsPreamble = 4'd6;
  localparam logic [3:0]  BitsDone     = 4'd0;
  localparam logic [7:0]  MaxSyncErr   = 8'd2;

  localparam logic [15:0] ResetPoly    = 16'h1021;
  localparam logic [7:0]  ResetLimit   = 8'd243;
  localparam logic [7:0]  ResetSync    = 8'h16;
  localparam logic [7:0]  ResetSoh     = 8'h01;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_PRE  = 4'd1,
    PH_BS1  = 4'd2,
    PH_BS2  = 4'd3,
    PH_SYN1 = 4'd4,
    PH_SYN2 = 4'd5,
    PH_SOH  = 4'd6,
    PH_TEXT = 4'd7,
    PH_CRC1 = 4'd8,
    PH_CRC2 = 4'd9,
    PH_END  = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    CFG_POLY       = 2'd0,
    CFG_TEXT_LIMIT = 2'd1,
    CFG_SYNC       = 2'd2,
    CFG_SOH        = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       channel;
  } in_item_t;

  typedef struct packed {
    logic [3:0] bits_next;
    logic       sign_reset;
    logic       char_valid;
    logic [6:0] char_out;
    logic [7:0] char_index;
    logic       frame_end;
    logic       frame_good;
    logic [7:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [15:0] crc_polynomial;
    logic [7:0]  text_limit;
    logic [7:0]  sync_char;
    logic [7:0]  start_of_header;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  count;
    logic [15:0] crc;
  } chan_state_t;

  // bit-serial CRC-16, data LSB first, eight steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    logic        top;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      top = c[15];
      c   = {c[14:0], data[k]};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/acfd_chan_state.sv -----
// ----------------------------------------------------------------------------
// acfd_chan_state
// Per-channel deframer state: phase, count and CRC register, one read
// and one write port indexed by channel.
// ----------------------------------------------------------------------------
module acfd_chan_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_chan_i,
  output acfd_pkg::chan_state_t rd_state_o,
  input  logic                  wr_en_i,
  input  logic                  wr_chan_i,
  input  acfd_pkg::chan_state_t wr_state_i
);

  acfd_pkg::chan_state_t state_q [acfd_pkg::CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < acfd_pkg::CHANNELS; c++) begin
        state_q[c].phase <= acfd_pkg::PH_HUNT;
        state_q[c].count <= '0;
        state_q[c].crc   <= '0;
      end
    end else if (wr_en_i) begin
      state_q[wr_chan_i] <= wr_state_i;
    end
  end

  assign rd_state_o = state_q[rd_chan_i];

endmodule

// ----- hdl/acfd_step.sv -----
// ----------------------------------------------------------------------------
// acfd_step
// Combinational deframer step: from one byte and its channel's state,
// the next state and the result word.
// ----------------------------------------------------------------------------
module acfd_step (
  input  acfd_pkg::in_item_t    item_i,
  input  acfd_pkg::chan_state_t state_i,
  input  acfd_pkg::cfg_t        cfg_i,
  output acfd_pkg::chan_state_t state_o,
  output acfd_pkg::out_item_t   res_o
);

  logic [7:0]  r;
  logic [6:0]  ch;
  logic [2:0]  ones;
  logic        run;
  logic [15:0] crc_upd;
  logic [7:0]  err_cnt;
  logic [8:0]  text_cnt;
  logic        is_ff;

  assign r       = item_i.byte_in;
  assign ch      = r[6:0];
  assign is_ff   = (r == acfd_pkg::PreambleByte);
  assign crc_upd = acfd_pkg::crc_byte(state_i.crc, r, cfg_i.crc_polynomial);

  // trailing ones among the low seven bits
  always_comb begin
    ones = '0;
    run  = 1'b1;
    for (int k = 0; k < 7; k++) begin
      if (run && r[k]) begin
        ones = ones + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    state_o  = state_i;
    res_o    = '0;
    res_o.bits_next = acfd_pkg::BitsByte;
    err_cnt  = '0;
    text_cnt = '0;
    unique case (state_i.phase)
      acfd_pkg::PH_PRE: begin
        if (is_ff) begin
          res_o.bits_next = acfd_pkg::BitsPreamble;
        end else if (ones < 3'd2) begin
          state_o.phase    = acfd_pkg::PH_HUNT;
          res_o.sign_reset = 1'b1;
        end else if (ones != 3'd2) begin
          state_o.count   = '0;
          state_o.phase   = acfd_pkg::PH_BS1;
          res_o.bits_next = {1'b0, ones - 3'd2};
        end else begin
          state_o.count = {7'd0, r != acfd_pkg::BitSync1};
          state_o.phase = acfd_pkg::PH_BS2;
        end
      end
      acfd_pkg::PH_BS1: begin
        state_o.count = state_i.count + {7'd0, r != acfd_pkg::BitSync1};
        state_o.phase = acfd_pkg::PH_BS2;
      end
      acfd_pkg::PH_BS2: begin
        state_o.count = state_i.count + {7'd0, r != acfd_pkg::BitSync2};
        state_o.phase = acfd_pkg::PH_SYN1;
      end
      acfd_pkg::PH_SYN1: begin
        state_o.count = state_i.count + {7'd0, r != cfg_i.sync_char};
        state_o.phase = acfd_pkg::PH_SYN2;
      end
      acfd_pkg::PH_SYN2: begin
        state_o.count = state_i.count + {7'd0, r != cfg_i.sync_char};
        state_o.phase = acfd_pkg::PH_SOH;
      end
      acfd_pkg::PH_SOH: begin
        err_cnt = state_i.count + {7'd0, r != cfg_i.start_of_header};
        if (err_cnt > acfd_pkg::MaxSyncErr) begin
          state_o.count    = err_cnt;
          state_o.phase    = is_ff ? acfd_pkg::PH_PRE : acfd_pkg::PH_HUNT;
          res_o.sign_reset = !is_ff;
        end else begin
          state_o.count = '0;
          state_o.crc   = '0;
          state_o.phase = acfd_pkg::PH_TEXT;
        end
      end
      acfd_pkg::PH_TEXT: begin
        state_o.crc = crc_upd;
        if (ch == acfd_pkg::CharEtx || ch == acfd_pkg::CharEtb) begin
          state_o.phase = acfd_pkg::PH_CRC1;
        end else begin
          text_cnt         = {1'b0, state_i.count} + 9'd1;
          res_o.char_valid = 1'b1;
          res_o.char_out   = ch;
          res_o.char_index = state_i.count;
          state_o.count    = text_cnt[7:0];
          if (text_cnt > {1'b0, cfg_i.text_limit}) begin
            state_o.phase    = acfd_pkg::PH_HUNT;
            res_o.sign_reset = 1'b1;
          end
        end
      end
      acfd_pkg::PH_CRC1: begin
        state_o.crc   = crc_upd;
        state_o.phase = acfd_pkg::PH_CRC2;
      end
      acfd_pkg::PH_CRC2: begin
        state_o.crc   = crc_upd;
        state_o.phase = acfd_pkg::PH_END;
      end
      acfd_pkg::PH_END: begin
        state_o.phase      = acfd_pkg::PH_HUNT;
        res_o.frame_end    = 1'b1;
        res_o.frame_length = state_i.count;
        if (state_i.crc == '0) begin
          res_o.frame_good = 1'b1;
          res_o.bits_next  = acfd_pkg::BitsDone;
        end
      end
      default: begin
        state_o.phase    = is_ff ? acfd_pkg::PH_PRE : acfd_pkg::PH_HUNT;
        res_o.sign_reset = !is_ff;
      end
    endcase
  end

endmodule

// ----- hdl/acars_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// acars_frame_deframer_unit
// ACARS byte deframer for two channels with bit-serial CRC-16 check.
// Pipeline: two register stages (input register, then result register); the
//   result word is registered behind its input word; an output stall can hold it.
// Throughput: one word per cycle while the output is not stalled, any channel order; the step is one pass.
// Reset: all channels return to preamble hunt, counts and CRCs cleared,
//   configuration registers take their default values.
// ----------------------------------------------------------------------------
module acars_frame_deframer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  acfd_pkg::cfg_reg_e  cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acfd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acfd_pkg::out_item_t out_data_o
);

  acfd_pkg::cfg_t        cfg_q;
  logic                  in_vld_q;
  acfd_pkg::in_item_t    in_item_q;
  logic                  out_vld_q;
  acfd_pkg::out_item_t   out_res_q;
  logic                  out_ready;
  logic                  fire;
  logic                  in_accept;
  acfd_pkg::chan_state_t cur_state;
  acfd_pkg::chan_state_t nxt_state;
  acfd_pkg::out_item_t   step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_polynomial  <= acfd_pkg::ResetPoly;
      cfg_q.text_limit      <= acfd_pkg::ResetLimit;
      cfg_q.sync_char       <= acfd_pkg::ResetSync;
      cfg_q.start_of_header <= acfd_pkg::ResetSoh;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        acfd_pkg::CFG_POLY:       cfg_q.crc_polynomial  <= cfg_data_i;
        acfd_pkg::CFG_TEXT_LIMIT: cfg_q.text_limit      <= cfg_data_i[7:0];
        acfd_pkg::CFG_SYNC:       cfg_q.sync_char       <= cfg_data_i[7:0];
        acfd_pkg::CFG_SOH:        cfg_q.start_of_header <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_data_i;
    end
  end

  acfd_chan_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_chan_i  (in_item_q.channel),
    .rd_state_o (cur_state),
    .wr_en_i    (fire),
    .wr_chan_i  (in_item_q.channel),
    .wr_state_i (nxt_state)
  );

  acfd_step u_step (
    .item_i  (in_item_q),
    .state_i (cur_state),
    .cfg_i   (cfg_q),
    .state_o (nxt_state),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_res_q;

endmodule

// ----- hdl/acfd_checker.sv -----
// ----------------------------------------------------------------------------
// acfd_checker
// Port-level checks of the deframer's result channel, bound to the top.
// ----------------------------------------------------------------------------
module acfd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input acfd_pkg::out_item_t out_data_o
);

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  ap_good_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_good |->
      out_data_o.frame_end && out_data_o.bits_next == acfd_pkg::BitsDone)
    else $error("good frame without end or nonzero bit count");

  ap_bad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end && !out_data_o.frame_good |->
      out_data_o.bits_next == acfd_pkg::BitsByte && !out_data_o.char_valid)
    else $error("bad frame end with wrong bit count or character");

  ap_char_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.char_valid |->
      out_data_o.char_out == '0 && out_data_o.char_index == '0)
    else $error("character fields set without a character");

  ap_char_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_valid |->
      out_data_o.char_out != acfd_pkg::CharEtx &&
      out_data_o.char_out != acfd_pkg::CharEtb)
    else $error("end-of-text character emitted as text");

endmodule

bind acars_frame_deframer_unit acfd_checker u_acfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
